@@ hw/rtl/pdwt_pkg.sv @@
// ----------------------------------------------------------------------------
// pdwt_pkg
// Shared types and constants for the pending/done worklist table: table
// sizes, opcodes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package pdwt_pkg;

    // table geometry
    localparam int PENDING_DEPTH = 1024;
    localparam int DONE_DEPTH    = 2048;
    localparam int ADDR_W        = 32;

    // slot index and fill count widths
    localparam int P_AW = $clog2(PENDING_DEPTH);
    localparam int P_CW = $clog2(PENDING_DEPTH + 1);
    localparam int D_AW = $clog2(DONE_DEPTH);
    localparam int D_CW = $clog2(DONE_DEPTH + 1);

    // stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    // address that add never enters
    localparam logic [ADDR_W-1:0] IGNORED_ADDRESS = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_MARK  = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // pending scan match rule
    typedef enum logic [1:0] {
        PM_ZERO    = 2'd0,
        PM_ADDR    = 2'd1,
        PM_NONZERO = 2'd2
    } pmode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_PSCAN,
        ST_ADD_DSCAN,
        ST_MARK_PSCAN,
        ST_MARK_DONE,
        ST_Q_PSCAN,
        ST_Q_DSCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic   in_load;
        logic   p_start;
        logic   p_resume;
        logic   p_run;
        pmode_t p_mode;
        logic   d_start;
        logic   d_run;
        logic   d_key_cand;
        logic   slot_hit;
        logic   slot_new;
        logic   pend_wr_add;
        logic   pend_wr_clr;
        logic   done_wr;
        logic   cand_load;
        logic   res_clear;
        logic   res_found;
        logic   res_all;
        logic   tables_clear;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic addr_zero;
        logic addr_ign;
        logic p_hit;
        logic p_end;
        logic p_full;
        logic d_hit;
        logic d_end;
        logic out_busy;
    } sts_t;

endpackage

@@ hw/rtl/pdwt_ram.sv @@
// ----------------------------------------------------------------------------
// pdwt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module pdwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/pdwt_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdwt_ctrl
// Controller: sequences the table scans and writes of one operation and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pdwt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output pdwt_pkg::cmd_t cmd,
    input  pdwt_pkg::sts_t sts
);
    import pdwt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.p_mode = PM_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.res_clear = 1'b1;
                unique case (sts.op)
                    OP_ADD:
                    begin
                        if (sts.addr_zero || sts.addr_ign)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.p_start = 1'b1;
                            state_next  = ST_ADD_PSCAN;
                        end
                    end
                    OP_MARK:
                    begin
                        if (sts.addr_zero)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.p_start = 1'b1;
                            state_next  = ST_MARK_PSCAN;
                        end
                    end
                    OP_QUERY:
                    begin
                        cmd.p_start = 1'b1;
                        state_next  = ST_Q_PSCAN;
                    end
                    OP_CLEAR:
                    begin
                        cmd.tables_clear = 1'b1;
                        state_next       = ST_FINISH;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            // look for the first free pending slot
            ST_ADD_PSCAN:
            begin
                cmd.p_run  = 1'b1;
                cmd.p_mode = PM_ZERO;
                if (sts.p_hit)
                begin
                    cmd.slot_hit = 1'b1;
                    cmd.d_start  = 1'b1;
                    state_next   = ST_ADD_DSCAN;
                end
                else if (sts.p_end)
                begin
                    if (sts.p_full)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.slot_new = 1'b1;
                        cmd.d_start  = 1'b1;
                        state_next   = ST_ADD_DSCAN;
                    end
                end
            end
            // skip the add if the address is already done
            ST_ADD_DSCAN:
            begin
                cmd.d_run = 1'b1;
                if (sts.d_hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.d_end)
                begin
                    cmd.pend_wr_add = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            // clear the first matching pending slot
            ST_MARK_PSCAN:
            begin
                cmd.p_run  = 1'b1;
                cmd.p_mode = PM_ADDR;
                if (sts.p_hit)
                begin
                    cmd.pend_wr_clr = 1'b1;
                    state_next      = ST_MARK_DONE;
                end
                else if (sts.p_end)
                begin
                    state_next = ST_MARK_DONE;
                end
            end
            ST_MARK_DONE:
            begin
                cmd.done_wr = 1'b1;
                state_next  = ST_FINISH;
            end
            // next live pending entry
            ST_Q_PSCAN:
            begin
                cmd.p_run  = 1'b1;
                cmd.p_mode = PM_NONZERO;
                if (sts.p_hit)
                begin
                    cmd.cand_load = 1'b1;
                    cmd.d_start   = 1'b1;
                    state_next    = ST_Q_DSCAN;
                end
                else if (sts.p_end)
                begin
                    cmd.res_all = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            // candidate already done: resume the pending scan after it
            ST_Q_DSCAN:
            begin
                cmd.d_run      = 1'b1;
                cmd.d_key_cand = 1'b1;
                if (sts.d_hit)
                begin
                    cmd.p_resume = 1'b1;
                    state_next   = ST_Q_PSCAN;
                end
                else if (sts.d_end)
                begin
                    cmd.res_found = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/pdwt_datapath.sv @@
// ----------------------------------------------------------------------------
// pdwt_datapath
// Datapath: pending and done tables, their fill counts, the two scan
// pipelines, working registers and the output register.
// ----------------------------------------------------------------------------
module pdwt_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pdwt_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [pdwt_pkg::S_TUSER_W-1:0]      s_tuser,
    input  pdwt_pkg::cmd_t                      cmd,
    output pdwt_pkg::sts_t                      sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pdwt_pkg::M_TDATA_W-1:0]      m_tdata
);
    import pdwt_pkg::*;

    // working registers
    op_t               op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] cand_reg;
    logic [P_AW-1:0]   slot_reg;
    logic              slot_new_reg;
    logic [ADDR_W-1:0] nd_reg;
    logic              ad_reg;

    // fill counts: pending high-water mark and done count
    logic [P_CW-1:0]   hw_reg;
    logic [D_CW-1:0]   dcnt_reg;

    // scan pipelines
    logic [P_CW-1:0]   pidx_reg;
    logic [P_AW-1:0]   p_didx_reg;
    logic              p_vld_reg;
    logic [D_CW-1:0]   didx_reg;
    logic              d_vld_reg;

    // output register
    logic              m_tvalid_reg;
    logic [ADDR_W-1:0] out_echo_reg;
    logic [ADDR_W-1:0] out_nd_reg;
    logic              out_ad_reg;

    // memory ports
    logic              p_re;
    logic              p_we;
    logic [P_AW-1:0]   p_waddr;
    logic [ADDR_W-1:0] p_wdata;
    logic [ADDR_W-1:0] p_rdata;
    logic              d_re;
    logic              d_we;
    logic [ADDR_W-1:0] d_rdata;

    logic              p_match;
    logic [ADDR_W-1:0] d_key;
    logic              p_full;
    logic              d_full;

    assign p_full = (hw_reg == P_CW'(PENDING_DEPTH));
    assign d_full = (dcnt_reg == D_CW'(DONE_DEPTH));
    assign p_re   = cmd.p_run && (pidx_reg < hw_reg);
    assign d_re   = cmd.d_run && (didx_reg < dcnt_reg);

    // pending write: add at the chosen slot or clear the matched slot
    assign p_we    = cmd.pend_wr_add || cmd.pend_wr_clr;
    assign p_waddr = cmd.pend_wr_add ? slot_reg : p_didx_reg;
    assign p_wdata = cmd.pend_wr_add ? addr_reg : '0;
    assign d_we    = cmd.done_wr && !d_full;

    pdwt_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (pidx_reg[P_AW-1:0]),
        .rdata (p_rdata)
    );

    pdwt_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (DONE_DEPTH)
    ) u_done_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (dcnt_reg[D_AW-1:0]),
        .wdata (addr_reg),
        .re    (d_re),
        .raddr (didx_reg[D_AW-1:0]),
        .rdata (d_rdata)
    );

    // match rules
    always_comb
    begin
        unique case (cmd.p_mode)
            PM_ZERO:    p_match = (p_rdata == '0);
            PM_ADDR:    p_match = (p_rdata == addr_reg);
            PM_NONZERO: p_match = (p_rdata != '0);
            default:    p_match = 1'b0;
        endcase
    end

    assign d_key = cmd.d_key_cand ? cand_reg : addr_reg;

    // status back to the controller
    always_comb
    begin
        sts           = '0;
        sts.op        = op_reg;
        sts.addr_zero = (addr_reg == '0);
        sts.addr_ign  = (addr_reg == IGNORED_ADDRESS);
        sts.p_hit     = p_vld_reg && p_match;
        sts.p_end     = !p_vld_reg && !(pidx_reg < hw_reg);
        sts.p_full    = p_full;
        sts.d_hit     = d_vld_reg && (d_rdata == d_key);
        sts.d_end     = !d_vld_reg && !(didx_reg < dcnt_reg);
        sts.out_busy  = m_tvalid_reg && !m_tready;
    end

    // scan counters and fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg    <= '0;
            dcnt_reg  <= '0;
            pidx_reg  <= '0;
            p_vld_reg <= 1'b0;
            didx_reg  <= '0;
            d_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.tables_clear)
            begin
                hw_reg <= '0;
            end
            else if (cmd.pend_wr_add && slot_new_reg)
            begin
                hw_reg <= hw_reg + P_CW'(1);
            end

            if (cmd.tables_clear)
            begin
                dcnt_reg <= '0;
            end
            else if (d_we)
            begin
                dcnt_reg <= dcnt_reg + D_CW'(1);
            end

            priority if (cmd.p_start)
            begin
                pidx_reg <= '0;
            end
            else if (cmd.p_resume)
            begin
                pidx_reg <= P_CW'(p_didx_reg) + P_CW'(1);
            end
            else if (p_re)
            begin
                pidx_reg <= pidx_reg + P_CW'(1);
            end
            else
            begin
                pidx_reg <= pidx_reg;
            end
            p_vld_reg <= p_re && !cmd.p_start && !cmd.p_resume;

            if (cmd.d_start)
            begin
                didx_reg <= '0;
            end
            else if (d_re)
            begin
                didx_reg <= didx_reg + D_CW'(1);
            end
            d_vld_reg <= d_re && !cmd.d_start;
        end
    end

    // payload working registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            op_reg   <= op_t'(s_tuser);
            addr_reg <= s_tdata;
        end
        // keep the index of a hit so a query resumes right after it
        if (p_re && !sts.p_hit)
        begin
            p_didx_reg <= pidx_reg[P_AW-1:0];
        end
        if (cmd.slot_hit)
        begin
            slot_reg     <= p_didx_reg;
            slot_new_reg <= 1'b0;
        end
        else if (cmd.slot_new)
        begin
            slot_reg     <= hw_reg[P_AW-1:0];
            slot_new_reg <= 1'b1;
        end
        if (cmd.cand_load)
        begin
            cand_reg <= p_rdata;
        end
        priority if (cmd.res_clear)
        begin
            nd_reg <= '0;
            ad_reg <= 1'b0;
        end
        else if (cmd.res_found)
        begin
            nd_reg <= cand_reg;
            ad_reg <= 1'b0;
        end
        else if (cmd.res_all)
        begin
            nd_reg <= '0;
            ad_reg <= 1'b1;
        end
        else
        begin
            nd_reg <= nd_reg;
            ad_reg <= ad_reg;
        end
        if (cmd.out_load)
        begin
            out_echo_reg <= addr_reg;
            out_nd_reg   <= nd_reg;
            out_ad_reg   <= ad_reg;
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_ad_reg, out_nd_reg, out_echo_reg};

endmodule

@@ hw/rtl/pending_done_worklist_table.sv @@
// ----------------------------------------------------------------------------
// pending_done_worklist_table
// Worklist of 32-bit addresses with a pending table and a done table;
// add, mark-done, query and clear operations, one result beat per input.
// ----------------------------------------------------------------------------
// One item is handled at a time; the next input beat is taken as soon as the
// previous item's result sits in the output register. Both tables live in
// single-read-port RAMs and every scan reads one entry per clock while it
// runs, so the cost of an item follows the fill of the tables: clear needs
// no scan, add scans the pending slots up to H and then the done entries,
// and mark-done scans the pending slots up to H, where H is the pending
// high-water mark (the number of slots used since the last clear). A query
// walks the pending slots and, for each live entry, the done table. The
// tables are tracked by fill counts, so reset and clear need no sweep and
// the block is ready right after reset.
module pending_done_worklist_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // address [31:0]
    input  logic [pdwt_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode [1:0]
    input  logic [pdwt_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // echo_address [31:0], not_done_address [63:32], all_done [64], zero [71:65]
    output logic [pdwt_pkg::M_TDATA_W-1:0]     m_tdata
);
    import pdwt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // operation sequencer
    pdwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // tables, scans and result register
    pdwt_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
